FILE: rtl/scm_pkg.sv
package scm_pkg;

  // Pi in Q62, the source of every angle-format constant.
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  // Fraction bits of the series magnitudes and the shift used with reciprocals.
  localparam int SER_FRAC  = 60;
  localparam int RCP_SHIFT = 63;

  // Reduction register: one integer bit more than the cosine shift needs.
  localparam int RED_W = 34;

  // Largest term count that the reciprocal table serves.
  localparam int MAX_TERMS = 16;
  localparam int RCP_IDX_W = $clog2(MAX_TERMS);

  // Rounded reciprocals round(2^63 / ((2i)(2i+1))). Entry zero is never used.
  localparam logic [63:0] RECIP [MAX_TERMS] = '{
    64'd0,
    (64'h8000000000000000 + 64'd3) / 64'd6,
    (64'h8000000000000000 + 64'd10) / 64'd20,
    (64'h8000000000000000 + 64'd21) / 64'd42,
    (64'h8000000000000000 + 64'd36) / 64'd72,
    (64'h8000000000000000 + 64'd55) / 64'd110,
    (64'h8000000000000000 + 64'd78) / 64'd156,
    (64'h8000000000000000 + 64'd105) / 64'd210,
    (64'h8000000000000000 + 64'd136) / 64'd272,
    (64'h8000000000000000 + 64'd171) / 64'd342,
    (64'h8000000000000000 + 64'd210) / 64'd420,
    (64'h8000000000000000 + 64'd253) / 64'd506,
    (64'h8000000000000000 + 64'd300) / 64'd600,
    (64'h8000000000000000 + 64'd351) / 64'd702,
    (64'h8000000000000000 + 64'd406) / 64'd812,
    (64'h8000000000000000 + 64'd465) / 64'd930
  };

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MAG,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_RCP_GO,
    ST_RCP_WAIT,
    ST_X2_GO,
    ST_X2_WAIT,
    ST_FINISH
  } state_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_RCP,
    MUL_X2
  } mul_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load;
    logic                 red_step;
    logic                 mag_load;
    logic                 mul_start;
    mul_op_t              mul_op;
    logic [RCP_IDX_W-1:0] rcp_idx;
    logic                 wr_x2;
    logic                 wr_term;
    logic                 acc_term;
    logic                 out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic red_done;
    logic mul_busy;
    logic mul_done;
  } dp_sts_t;

endpackage

FILE: rtl/scm_if.sv
// Input channel: selector and angle.
interface scm_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] angle;

  modport source (output valid, output kind, output angle, input ready);
  modport sink (input valid, input kind, input angle, output ready);
endinterface

// Output channel: series value.
interface scm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

FILE: rtl/scm_mul.sv
module scm_mul
  import scm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic        rcp,
  output logic        busy,
  output logic        done,
  output logic [63:0] res
);

  localparam int MUL_STEPS = 4;
  localparam int ACC_W     = 128;
  localparam int CNT_W     = $clog2(MUL_STEPS + 1);

  localparam logic [ACC_W-1:0] RND_Q60 = ACC_W'(1) << (SER_FRAC - 1);
  localparam logic [ACC_W-1:0] RND_RCP = ACC_W'(1) << (RCP_SHIFT - 1);

  logic [CNT_W-1:0] cnt;
  logic [63:0]      a_r;
  logic [63:0]      b_r;
  logic             rcp_r;
  logic [63:0]      pp;
  logic [1:0]       pp_off;
  logic [ACC_W-1:0] acc;
  logic [31:0]      a_part;
  logic [31:0]      b_part;
  logic [1:0]       off;

  // Quarter selection: low-low, low-high, high-low, high-high.
  assign a_part = cnt[1] ? a_r[63:32] : a_r[31:0];
  assign b_part = cnt[0] ? b_r[63:32] : b_r[31:0];
  assign off    = {cnt[1] & cnt[0], cnt[1] ^ cnt[0]};

  // Step control: four partial products, then a final step that adds the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The accumulator starts at the rounding constant, so the sum needs no final add.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      rcp_r <= rcp;
      acc   <= rcp ? RND_RCP : RND_Q60;
    end else if (busy) begin
      if (cnt != CNT_W'(MUL_STEPS)) begin
        pp     <= a_part * b_part;
        pp_off <= off;
      end
      if (cnt != '0) begin
        acc <= acc + (ACC_W'(pp) << {pp_off, 5'b00000});
      end
    end
  end

  assign res = rcp_r ? acc[RCP_SHIFT+63:RCP_SHIFT] : acc[SER_FRAC+63:SER_FRAC];

endmodule

FILE: rtl/scm_datapath.sv
module scm_datapath
  import scm_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 26
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               kind,
  input  logic signed [31:0] angle,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  output logic signed [31:0] value
);

  // Angle-format constants, rounded half up from the Q62 pi.
  localparam int SH_PI  = 62 - ANGLE_FRAC_BITS;
  localparam int SH_HP  = 63 - ANGLE_FRAC_BITS;
  localparam int MAG_SH = SER_FRAC - ANGLE_FRAC_BITS;
  localparam logic [64:0] PI_FULL =
    ({1'b0, PI_Q62} + (65'd1 << (SH_PI - 1))) >> SH_PI;
  localparam logic [64:0] HP_FULL =
    ({1'b0, PI_Q62} + (65'd1 << (SH_HP - 1))) >> SH_HP;
  localparam logic signed [RED_W-1:0] PI_A     = $signed(PI_FULL[RED_W-1:0]);
  localparam logic signed [RED_W-1:0] HALF_PI_A = $signed(HP_FULL[RED_W-1:0]);
  localparam logic signed [RED_W-1:0] TWO_PI_A = PI_A + PI_A;

  logic signed [RED_W-1:0] x;
  logic [63:0]             mag;
  logic [63:0]             x2;
  logic [63:0]             term;
  logic                    tneg;
  logic signed [63:0]      sum;
  logic                    x_hi;
  logic                    x_lo;
  logic [RED_W-1:0]        xabs;
  logic [63:0]             mag_w;
  logic [63:0]             mul_a;
  logic [63:0]             mul_b;
  logic [63:0]             mul_res;
  logic                    mul_busy;
  logic                    mul_done;
  logic [63:0]             biased;
  logic signed [33:0]      res34;
  logic signed [31:0]      sat;

  // Range tests for the whole-turn reduction.
  assign x_hi = x > PI_A;
  assign x_lo = x < -PI_A;

  // Magnitude of the reduced angle, moved into Q60.
  assign xabs  = x[RED_W-1] ? RED_W'(-x) : RED_W'(x);
  assign mag_w = 64'(xabs) << MAG_SH;

  // Operands of the shared multiplier.
  always_comb begin
    case (cmd.mul_op)
      MUL_SQ: begin
        mul_a = mag;
        mul_b = mag;
      end
      MUL_RCP: begin
        mul_a = term;
        mul_b = RECIP[cmd.rcp_idx];
      end
      MUL_X2: begin
        mul_a = term;
        mul_b = x2;
      end
      default: begin
        mul_a = term;
        mul_b = x2;
      end
    endcase
  end

  scm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .rcp   (cmd.mul_op == MUL_RCP),
    .busy  (mul_busy),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Rounding to Q2.30 through a biased unsigned shift, then saturation.
  assign biased = 64'(sum) + 64'h8000_0000_2000_0000;
  assign res34  = $signed({~biased[63], biased[62:30]});
  always_comb begin
    if (res34[33:31] == 3'b000 || res34[33:31] == 3'b111) begin
      sat = res34[31:0];
    end else if (res34[33]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7FFF_FFFF;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= RED_W'(angle) + (kind ? HALF_PI_A : RED_W'(0));
    end else if (cmd.red_step) begin
      if (x_hi) begin
        x <= x - TWO_PI_A;
      end else if (x_lo) begin
        x <= x + TWO_PI_A;
      end
    end
    if (cmd.mag_load) begin
      mag  <= mag_w;
      term <= mag_w;
      tneg <= x[RED_W-1];
      sum  <= x[RED_W-1] ? -$signed(mag_w) : $signed(mag_w);
    end
    if (cmd.wr_x2) begin
      x2 <= mul_res;
    end
    if (cmd.wr_term || cmd.acc_term) begin
      term <= mul_res;
    end
    if (cmd.acc_term) begin
      tneg <= ~tneg;
      sum  <= tneg ? sum + $signed(mul_res) : sum - $signed(mul_res);
    end
    if (cmd.out_load) begin
      value <= sat;
    end
  end

  assign sts.red_done = ~x_hi & ~x_lo;
  assign sts.mul_busy = mul_busy;
  assign sts.mul_done = mul_done;

endmodule

FILE: rtl/scm_ctrl.sv
module scm_ctrl
  import scm_pkg::*;
#(
  parameter int TERMS = 10
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam int IDX_W = $clog2(TERMS);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             out_valid_next;

  // State, term index and output flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_op   = MUL_SQ;
    cmd.rcp_idx  = RCP_IDX_W'(idx);
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
        if (sts.red_done) begin
          state_next = ST_MAG;
        end
      end
      ST_MAG: begin
        cmd.mag_load = 1'b1;
        idx_next     = IDX_W'(1);
        state_next   = ST_SQ_GO;
      end
      ST_SQ_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (sts.mul_done) begin
          cmd.wr_x2  = 1'b1;
          state_next = ST_RCP_GO;
        end
      end
      ST_RCP_GO: begin
        cmd.mul_op    = MUL_RCP;
        cmd.mul_start = 1'b1;
        state_next    = ST_RCP_WAIT;
      end
      ST_RCP_WAIT: begin
        cmd.mul_op = MUL_RCP;
        if (sts.mul_done) begin
          cmd.wr_term = 1'b1;
          state_next  = ST_X2_GO;
        end
      end
      ST_X2_GO: begin
        cmd.mul_op    = MUL_X2;
        cmd.mul_start = 1'b1;
        state_next    = ST_X2_WAIT;
      end
      ST_X2_WAIT: begin
        cmd.mul_op = MUL_X2;
        if (sts.mul_done) begin
          cmd.acc_term = 1'b1;
          if (idx == IDX_W'(TERMS - 1)) begin
            state_next = ST_FINISH;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_RCP_GO;
          end
        end
      end
      ST_FINISH: begin
        // Wait here only while the previous result has not been taken.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register flag.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

FILE: rtl/sine_cosine_maclaurin.sv
// Fixed-point sine and cosine by a truncated Maclaurin series.
//
// Input channel in_ch carries a selector (kind: 0 sine, 1 cosine) and a signed
// angle in radians with ANGLE_FRAC_BITS fraction bits. Output channel out_ch
// carries one signed Q2.30 value for every input beat, in order.
//
// An input beat is taken only while the block is idle. The angle is first
// brought into range by one whole turn of 2*pi per cycle (R turns, at most five
// at the default format), then TERMS-1 series terms are formed, each needing
// two products on one shared 64-by-64 multiplier that works through four
// 32-by-32 partial products. The block takes no new input beat until the
// result of the last one has been loaded into the output register.
//
// The result sits in an output register, so the next input beat is taken
// while the previous result waits; if the receiver still stalls when the next
// result is ready, the block holds it internally until the register frees.
// A synchronous reset returns the controller to idle and empties the output.
module sine_cosine_maclaurin
  import scm_pkg::*;
#(
  parameter int TERMS           = 10,
  parameter int ANGLE_FRAC_BITS = 26
) (
  input  logic      clk,
  input  logic      rst,
  scm_in_if.sink    in_ch,
  scm_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  scm_ctrl #(
    .TERMS (TERMS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scm_datapath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .kind  (in_ch.kind),
    .angle (in_ch.angle),
    .cmd   (cmd),
    .sts   (sts),
    .value (out_ch.value)
  );

  // The multiplier is never restarted while a product is in flight.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiplier started while busy");

  // Terms are written only from a finished product.
  a_term_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_term || cmd.acc_term || cmd.wr_x2) |-> sts.mul_done)
    else $error("term written without a finished product");

  // An accepted beat closes the input until its work is done.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input reopened straight after a beat");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten");

endmodule
